>>> sv/vacpp_pkg.sv
// Shared types, constants and helpers for the auto clock/phase/position sequencer.
package vacpp_pkg;

  localparam int PHASE_STEPS = 32;
  localparam int EDGE_OFFSET = 38;

  localparam int PH_W   = $clog2(PHASE_STEPS);
  localparam int PI_W   = $clog2(3 * PHASE_STEPS + 2);
  localparam int SCAN_W = $clog2(PHASE_STEPS + 2);

  localparam logic [10:0] LEFT_LIMIT  = 11'd2040;
  localparam logic [7:0]  CLK_CENTER  = 8'h80;
  localparam int          WIDTH_TOL   = 127;
  localparam logic [11:0] VSTART_TOL  = 12'd50;
  localparam logic [10:0] TOP_FLOOR   = 11'd200;
  localparam logic [10:0] TOP_MIN     = 11'd4;
  localparam logic [11:0] WIDE_MODE   = 12'd1280;
  localparam int          SNAP_RANGE  = 4;
  localparam logic [5:0]  NORM_BITS   = 6'd11;
  localparam logic [11:0] DOS_LINES_A = 12'd350;
  localparam logic [11:0] DOS_LINES_B = 12'd400;
  localparam logic [11:0] HSTART_SPAN = 12'hFF;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_MEAS  = 2'd1,
    ACT_ABORT = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    CMD_START_MEAS  = 4'd0,
    CMD_SET_TOTAL   = 4'd1,
    CMD_SET_PHASE   = 4'd2,
    CMD_DC_BIAS     = 4'd3,
    CMD_HSTART      = 4'd4,
    CMD_VSTART      = 4'd5,
    CMD_STORE_H     = 4'd6,
    CMD_STORE_V     = 4'd7,
    CMD_STORE_CLK   = 4'd8,
    CMD_STORE_PHASE = 4'd9,
    CMD_LEVELS      = 4'd10,
    CMD_RESTORE     = 4'd11
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ACT_WIDTH   = 3'd0,
    REG_ACT_LINES   = 3'd1,
    REG_HSTART      = 3'd2,
    REG_VSTART      = 3'd3,
    REG_NOM_TOTAL   = 3'd4,
    REG_TARGET      = 3'd5,
    REG_START_TOTAL = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    STEP_IDLE  = 2'd0,
    STEP_EDGES = 2'd1,
    STEP_SUMS  = 2'd2
  } step_t;

  typedef enum logic [1:0] {
    CLK_FALLBACK = 2'd0,
    CLK_MATCH    = 2'd1,
    CLK_UP       = 2'd2,
    CLK_DOWN     = 2'd3
  } clk_class_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_ABORT, OP_START, OP_START_BIAS, OP_BEGIN, OP_EDGES, OP_SUM,
    OP_DOS, OP_UNSTABLE, OP_CLK_EVAL, OP_CLK_FALLBACK, OP_CLK_MATCH, OP_CLK_STEP,
    OP_AFTER_CLK, OP_SET_PHASE, OP_NORM_INIT, OP_NORM_STEP, OP_SUM_STORE,
    OP_SCAN_INIT, OP_SCAN_STEP, OP_PH_BEST, OP_PH_BIAS, OP_DIV_INIT, OP_DIV_STEP,
    OP_POS_H, OP_POS_V, OP_POS_VSKIP, OP_RESTORE, OP_STORE_H, OP_STORE_V, OP_STORE_CLK,
    OP_STORE_PH
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_START_BIAS, S_BEGIN, S_CLK_CHECK, S_DOS, S_UNSTABLE, S_CLK_EVAL,
    S_CLK_BRANCH, S_AFTER_CLK, S_PHASE_POINT, S_NORM_INIT, S_NORM, S_SUM_STORE,
    S_SCAN_INIT, S_SCAN, S_PH_BEST, S_PH_BIAS, S_DIV_INIT, S_DIV, S_POS_H, S_POS_V,
    S_RESTORE, S_STORE_H, S_STORE_V, S_STORE_CLK, S_STORE_PH
  } fsm_t;

  typedef struct packed {
    logic [11:0] act_width;
    logic [11:0] act_lines;
    logic [11:0] hstart;
    logic [11:0] vstart;
    logic [11:0] nom_total;
    logic [11:0] target;
    logic [11:0] start_total;
  } cfg_t;

  typedef struct packed {
    logic [1:0] act;
    step_t      step;
    logic [1:0] colour;
    logic       phase_done;
    logic       pi_lt;
    logic       pi_zero;
    logic       dos;
    logic       unstable;
    clk_class_t clk_class;
    logic       norm_last;
    logic       scan_last;
    logic       div_last;
    logic       v_send;
    logic       out_free;
  } stat_t;

  function automatic logic op_emits(op_t op);
    logic e;
    case (op)
      OP_START, OP_START_BIAS, OP_BEGIN, OP_DOS, OP_UNSTABLE, OP_CLK_FALLBACK,
      OP_CLK_MATCH, OP_CLK_STEP, OP_AFTER_CLK, OP_SET_PHASE, OP_PH_BEST, OP_PH_BIAS,
      OP_POS_H, OP_POS_V, OP_RESTORE, OP_STORE_H, OP_STORE_V, OP_STORE_CLK,
      OP_STORE_PH: e = 1'b1;
      default:     e = 1'b0;
    endcase
    return e;
  endfunction

endpackage

>>> sv/vacpp_ctrl.sv
// Sequencer state machine: walks each item through the datapath operations.
module vacpp_ctrl
  import vacpp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  stat_t stat,
  output logic  in_stall,
  output op_t   op
);

  fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.act == ACT_ABORT) begin
          op         = OP_ABORT;
          state_next = S_IDLE;
        end else if (stat.act == ACT_START) begin
          if (stat.out_free) begin
            op         = OP_START;
            state_next = S_START_BIAS;
          end
        end else if (stat.act == ACT_MEAS && stat.colour != 2'd0 &&
                     stat.step == STEP_EDGES) begin
          op = OP_EDGES;
          if (stat.colour != 2'd3)  state_next = S_BEGIN;
          else if (!stat.phase_done) state_next = S_CLK_CHECK;
          else                       state_next = S_DIV_INIT;
        end else if (stat.act == ACT_MEAS && stat.colour != 2'd0 &&
                     stat.step == STEP_SUMS) begin
          op = OP_SUM;
          if (stat.colour != 2'd3) state_next = S_BEGIN;
          else if (stat.pi_zero)    state_next = S_NORM_INIT;
          else                      state_next = S_SUM_STORE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_START_BIAS: if (stat.out_free) begin
        op = OP_START_BIAS; state_next = S_BEGIN;
      end
      S_BEGIN: if (stat.out_free) begin
        op = OP_BEGIN; state_next = S_IDLE;
      end
      S_CLK_CHECK: begin
        if (stat.dos)           state_next = S_DOS;
        else if (stat.unstable) state_next = S_UNSTABLE;
        else                    state_next = S_CLK_EVAL;
      end
      S_DOS: if (stat.out_free) begin
        op = OP_DOS; state_next = S_AFTER_CLK;
      end
      S_UNSTABLE: if (stat.out_free) begin
        op = OP_UNSTABLE; state_next = S_BEGIN;
      end
      S_CLK_EVAL: begin
        op = OP_CLK_EVAL; state_next = S_CLK_BRANCH;
      end
      S_CLK_BRANCH: if (stat.out_free) begin
        case (stat.clk_class)
          CLK_FALLBACK: begin op = OP_CLK_FALLBACK; state_next = S_AFTER_CLK; end
          CLK_MATCH:    begin op = OP_CLK_MATCH;    state_next = S_AFTER_CLK; end
          default:      begin op = OP_CLK_STEP;     state_next = S_BEGIN;     end
        endcase
      end
      S_AFTER_CLK: if (stat.out_free) begin
        op = OP_AFTER_CLK; state_next = S_PHASE_POINT;
      end
      S_PHASE_POINT: begin
        if (!stat.pi_lt) begin
          state_next = S_SCAN_INIT;
        end else if (stat.out_free) begin
          op = OP_SET_PHASE; state_next = S_BEGIN;
        end
      end
      S_NORM_INIT: begin
        op = OP_NORM_INIT; state_next = S_NORM;
      end
      S_NORM: begin
        op = OP_NORM_STEP;
        if (stat.norm_last) state_next = S_SUM_STORE;
      end
      S_SUM_STORE: begin
        op = OP_SUM_STORE; state_next = S_PHASE_POINT;
      end
      S_SCAN_INIT: begin
        op = OP_SCAN_INIT; state_next = S_SCAN;
      end
      S_SCAN: begin
        op = OP_SCAN_STEP;
        if (stat.scan_last) state_next = S_PH_BEST;
      end
      S_PH_BEST: if (stat.out_free) begin
        op = OP_PH_BEST; state_next = S_PH_BIAS;
      end
      S_PH_BIAS: if (stat.out_free) begin
        op = OP_PH_BIAS; state_next = S_BEGIN;
      end
      S_DIV_INIT: begin
        op = OP_DIV_INIT; state_next = S_DIV;
      end
      S_DIV: begin
        op = OP_DIV_STEP;
        if (stat.div_last) state_next = S_POS_H;
      end
      S_POS_H: if (stat.out_free) begin
        op = OP_POS_H; state_next = S_POS_V;
      end
      S_POS_V: begin
        if (!stat.v_send) begin
          op = OP_POS_VSKIP; state_next = S_RESTORE;
        end else if (stat.out_free) begin
          op = OP_POS_V; state_next = S_RESTORE;
        end
      end
      S_RESTORE: if (stat.out_free) begin
        op = OP_RESTORE; state_next = S_STORE_H;
      end
      S_STORE_H: if (stat.out_free) begin
        op = OP_STORE_H; state_next = S_STORE_V;
      end
      S_STORE_V: if (stat.out_free) begin
        op = OP_STORE_V; state_next = S_STORE_CLK;
      end
      S_STORE_CLK: if (stat.out_free) begin
        op = OP_STORE_CLK; state_next = S_STORE_PH;
      end
      S_STORE_PH: if (stat.out_free) begin
        op = OP_STORE_PH; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> sv/vacpp_dp.sv
// Datapath: sequencer state, edge and phase-sum stores, arithmetic and output word register.
module vacpp_dp
  import vacpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  op_t         op,
  input  cfg_t        cfg,
  input  logic [1:0]  action,
  input  logic [10:0] left_edge,
  input  logic [10:0] right_edge,
  input  logic [10:0] top_edge,
  input  logic [31:0] window_sum,
  input  logic        out_stall,
  output stat_t       stat,
  output logic        out_valid,
  output logic [3:0]  command,
  output logic [11:0] argument,
  output logic        last
);

  // sequencer state
  step_t            step;
  logic [1:0]       colour;
  logic [11:0]      pixel_total;
  logic [PI_W-1:0]  pi;
  logic [PH_W-1:0]  pi_mod;
  logic [7:0]       search_count;
  logic             flag_stable, flag_clock, flag_phase;
  logic [31:0]      sum_acc;
  logic [5:0]       norm_shift;
  logic [31:0]      norm_tmp;
  logic [7:0]       saved [4];

  // latched input word
  logic [1:0]  in_act;
  logic [10:0] in_left, in_right, in_top;
  logic [31:0] in_sum;

  logic [10:0] edges [9];
  logic [31:0] sums [PHASE_STEPS];
  logic [31:0] mem_q;

  clk_class_t        clk_class;
  logic [SCAN_W-1:0] scan_cnt;
  logic [31:0]       scan_prev, best_d;
  logic [PH_W-1:0]   best_t;
  logic [1:0]        div_sel;
  logic [3:0]        div_bit;
  logic [11:0]       div_rem;
  logic [11:0]       lpos [3];

  // ---------------- combinational helpers ----------------
  logic        bias_add;
  logic [1:0]  col_next;
  step_t       step_begin;
  logic [11:0] nom_m1;

  assign bias_add   = (cfg.act_width >= WIDE_MODE) ? 1'b0 : 1'b1;
  assign col_next   = (colour == 2'd3) ? 2'd1 : colour + 2'd1;
  assign step_begin = (flag_clock && !flag_phase) ? STEP_SUMS : STEP_EDGES;
  assign nom_m1     = cfg.nom_total - 12'd1;

  // clock check: merge edges, classify width
  logic [10:0] ml, mr;
  logic [11:0] span;
  logic [11:0] active;
  logic signed [13:0] wdiff;
  clk_class_t  class_c;
  always_comb begin
    ml = edges[0];
    mr = edges[1];
    if (edges[3] >= edges[6] && edges[6] <= ml) ml = edges[6];
    if (edges[4] <= edges[7] && edges[7] >= mr) mr = edges[7];
    if (ml >= edges[3] && edges[3] <= edges[6]) ml = edges[3];
    if (edges[7] <= edges[4] && edges[4] >= mr) mr = edges[4];
    span   = {1'b0, mr} + 12'd2 - {1'b0, ml};
    active = {span[11:1], 1'b0};
    wdiff  = $signed({2'b00, active}) - $signed({2'b00, cfg.act_width});
    if (({1'b0, mr} + 12'd2) < {1'b0, ml})            class_c = CLK_FALLBACK;
    else if (wdiff > 14'sd127 || wdiff < -14'sd127)  class_c = CLK_FALLBACK;
    else if (active == cfg.target)                   class_c = CLK_MATCH;
    else if (active <= cfg.target)                   class_c = CLK_UP;
    else                                             class_c = CLK_DOWN;
  end

  // total adjustments
  logic signed [12:0] pt_d;
  logic [11:0]        pt_snap, pt_step, pt_m1;
  assign pt_d    = $signed({1'b0, pixel_total}) - $signed({1'b0, cfg.nom_total});
  assign pt_snap = (pt_d != 13'sd0 && pt_d <= 13'sd4 && pt_d >= -13'sd4) ?
                   cfg.nom_total : pixel_total;
  assign pt_m1   = pixel_total - 12'd1;
  assign pt_step = (clk_class == CLK_UP) ? pixel_total + 12'd1 : {pt_m1[11:1], 1'b0};

  // normalized sum
  logic [5:0]  nsh;
  logic [31:0] sum_norm;
  assign nsh      = (norm_shift > NORM_BITS) ? norm_shift - NORM_BITS : 6'd0;
  assign sum_norm = sum_acc >> nsh[4:0];

  // phase scan
  logic [PH_W-1:0] scan_addr;
  logic [31:0]     scan_d;
  logic [PH_W-1:0] scan_t;
  assign scan_addr = (scan_cnt >= SCAN_W'(PHASE_STEPS)) ? '0 : scan_cnt[PH_W-1:0];
  assign scan_d    = (scan_prev >= mem_q) ? scan_prev - mem_q : mem_q - scan_prev;
  assign scan_t    = PH_W'(scan_cnt - SCAN_W'(2));

  // remainder, one bit per cycle
  logic [10:0] div_e;
  logic [12:0] div_sh;
  logic [11:0] div_nx;
  always_comb begin
    case (div_sel)
      2'd0:    div_e = edges[0];
      2'd1:    div_e = edges[3];
      default: div_e = edges[6];
    endcase
    div_sh = {div_rem, div_e[div_bit]};
    div_nx = (div_sh >= {1'b0, cfg.nom_total}) ?
             12'(div_sh - {1'b0, cfg.nom_total}) : div_sh[11:0];
  end

  // position
  logic [15:0] lp0, lp1, lp2, hmin, hsel;
  logic [15:0] hlim;
  assign lp0  = {4'd0, lpos[0]} - 16'(EDGE_OFFSET);
  assign lp1  = {4'd0, lpos[1]} - 16'(EDGE_OFFSET);
  assign lp2  = {4'd0, lpos[2]} - 16'(EDGE_OFFSET);
  assign hlim = {4'd0, cfg.hstart} + {4'd0, HSTART_SPAN};
  always_comb begin
    if (lp0 <= lp1 && lp0 <= lp2)      hmin = lp0;
    else if (lp1 <= lp0 && lp1 <= lp2) hmin = lp1;
    else                               hmin = lp2;
    hsel = (hmin > hlim) ? {4'd0, cfg.hstart} : hmin;
  end

  logic [10:0] rt, gt, bt;
  logic        r_min, g_min;
  logic [12:0] vlim;
  logic [11:0] tsel, vval;
  logic        v_send;
  assign rt    = edges[2];
  assign gt    = edges[5];
  assign bt    = edges[8];
  assign r_min = (rt <= gt && rt <= bt);
  assign g_min = (gt <= rt && gt <= bt);
  assign vlim  = {1'b0, cfg.vstart} + {1'b0, VSTART_TOL};
  always_comb begin
    if (r_min || g_min) begin
      tsel   = r_min ? {1'b0, rt} : {1'b0, gt};
      v_send = ({1'b0, tsel} <= vlim);
    end else begin
      tsel   = ({2'b00, bt} > vlim) ? cfg.vstart : {1'b0, bt};
      v_send = 1'b1;
    end
    vval = (tsel >= 12'd4) ? tsel - 12'd4 : 12'd4 - tsel;
  end

  // pi bookkeeping for an unstable retry
  logic [PI_W-1:0] pi_inc;
  logic [PH_W-1:0] pi_mod_inc;
  assign pi_inc     = pi + PI_W'(1);
  assign pi_mod_inc = (pi_mod == PH_W'(PHASE_STEPS - 1)) ? '0 : pi_mod + PH_W'(1);

  // emitted word
  cmd_t        em_cmd;
  logic [11:0] em_arg;
  always_comb begin
    em_cmd = CMD_LEVELS;
    em_arg = 12'd0;
    case (op)
      OP_START:        begin em_cmd = CMD_LEVELS;      em_arg = 12'd0; end
      OP_START_BIAS:   begin em_cmd = CMD_DC_BIAS;     em_arg = {11'd0, bias_add}; end
      OP_BEGIN:        begin em_cmd = CMD_START_MEAS;  em_arg = {10'd0, col_next}; end
      OP_DOS:          begin em_cmd = CMD_SET_TOTAL;   em_arg = nom_m1; end
      OP_UNSTABLE:     begin em_cmd = CMD_SET_PHASE;   em_arg = 12'(pi_mod); end
      OP_CLK_FALLBACK: begin em_cmd = CMD_SET_TOTAL;   em_arg = nom_m1; end
      OP_CLK_MATCH:    begin em_cmd = CMD_SET_TOTAL;   em_arg = pt_snap - 12'd1; end
      OP_CLK_STEP:     begin em_cmd = CMD_SET_TOTAL;   em_arg = pt_step - 12'd1; end
      OP_AFTER_CLK:    begin em_cmd = CMD_DC_BIAS;     em_arg = 12'd2 + {11'd0, bias_add}; end
      OP_SET_PHASE:    begin em_cmd = CMD_SET_PHASE;   em_arg = 12'(pi); end
      OP_PH_BEST:      begin em_cmd = CMD_SET_PHASE;   em_arg = 12'(best_t); end
      OP_PH_BIAS:      begin em_cmd = CMD_DC_BIAS;     em_arg = 12'd4 + {11'd0, bias_add}; end
      OP_POS_H:        begin em_cmd = CMD_HSTART;      em_arg = hsel[11:0]; end
      OP_POS_V:        begin em_cmd = CMD_VSTART;      em_arg = vval; end
      OP_RESTORE:      begin em_cmd = CMD_RESTORE;     em_arg = 12'd0; end
      OP_STORE_H:      begin em_cmd = CMD_STORE_H;     em_arg = {4'd0, saved[0]}; end
      OP_STORE_V:      begin em_cmd = CMD_STORE_V;     em_arg = {4'd0, saved[1]}; end
      OP_STORE_CLK:    begin em_cmd = CMD_STORE_CLK;   em_arg = {4'd0, saved[2]}; end
      OP_STORE_PH:     begin em_cmd = CMD_STORE_PHASE; em_arg = {4'd0, saved[3]}; end
      default:         begin em_cmd = CMD_LEVELS;      em_arg = 12'd0; end
    endcase
  end

  // ---------------- control state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= STEP_IDLE;
      colour       <= 2'd0;
      pi           <= '0;
      pi_mod       <= '0;
      search_count <= 8'd0;
      flag_stable  <= 1'b0;
      flag_clock   <= 1'b0;
      flag_phase   <= 1'b0;
      sum_acc      <= 32'd0;
      norm_shift   <= 6'd0;
      saved[0]     <= 8'd0;
      saved[1]     <= 8'd0;
      saved[2]     <= 8'd0;
      saved[3]     <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      if (op_emits(op))   out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (op)
        OP_ABORT: begin
          step <= STEP_IDLE; colour <= 2'd0;
          flag_stable <= 1'b0; flag_clock <= 1'b0; flag_phase <= 1'b0;
        end
        OP_START: begin
          colour <= 2'd0; pi <= '0; pi_mod <= '0; search_count <= 8'd0;
          flag_stable <= 1'b0; flag_clock <= 1'b0; flag_phase <= 1'b0;
        end
        OP_BEGIN: begin
          colour <= col_next;
          step   <= step_begin;
        end
        OP_SUM: sum_acc <= (colour == 2'd1) ? in_sum : sum_acc + in_sum;
        OP_DOS: begin
          saved[2] <= CLK_CENTER; search_count <= 8'd0;
        end
        OP_UNSTABLE: begin
          if (pi_inc > PI_W'(3 * PHASE_STEPS)) begin
            flag_stable <= 1'b1; pi <= '0; pi_mod <= '0;
          end else begin
            pi <= pi_inc; pi_mod <= pi_mod_inc;
          end
        end
        OP_CLK_EVAL: flag_stable <= 1'b1;
        OP_CLK_FALLBACK: begin
          search_count <= 8'd0; pi <= '0; pi_mod <= '0; saved[2] <= CLK_CENTER;
        end
        OP_CLK_MATCH: begin
          search_count <= 8'd0; flag_stable <= 1'b0; pi <= '0; pi_mod <= '0;
          saved[2] <= 8'(CLK_CENTER + pt_snap[7:0] - cfg.nom_total[7:0]);
        end
        OP_CLK_STEP: begin
          colour <= 2'd0; flag_stable <= 1'b0; search_count <= search_count + 8'd1;
        end
        OP_AFTER_CLK: begin
          colour <= 2'd0; flag_clock <= 1'b1;
        end
        OP_NORM_INIT: norm_shift <= 6'd0;
        OP_NORM_STEP: norm_shift <= norm_shift + 6'd1;
        OP_SUM_STORE: pi <= pi_inc;
        OP_PH_BEST: begin
          pi <= PI_W'(best_t); saved[3] <= 8'(best_t); flag_phase <= 1'b1;
        end
        OP_POS_H:     saved[0] <= 8'(cfg.hstart[7:0] + CLK_CENTER - hsel[7:0]);
        OP_POS_V:     saved[1] <= vval[7:0];
        OP_POS_VSKIP: saved[1] <= cfg.vstart[7:0];
        OP_STORE_PH: begin
          step <= STEP_IDLE; colour <= 2'd0;
          flag_stable <= 1'b0; flag_clock <= 1'b0; flag_phase <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (op_emits(op)) begin
      command  <= em_cmd;
      argument <= em_arg;
      last     <= (em_cmd == CMD_START_MEAS) || (em_cmd == CMD_STORE_PHASE);
    end
    case (op)
      OP_LOAD: begin
        in_act <= action; in_left <= left_edge; in_right <= right_edge;
        in_top <= top_edge; in_sum <= window_sum;
      end
      OP_START:        pixel_total <= cfg.start_total;
      OP_DOS:          pixel_total <= cfg.nom_total;
      OP_CLK_FALLBACK: pixel_total <= cfg.nom_total;
      OP_CLK_MATCH:    pixel_total <= pt_snap;
      OP_CLK_STEP:     pixel_total <= pt_step;
      OP_EDGES: begin
        case (colour)
          2'd1: begin
            edges[0] <= in_left; edges[1] <= in_right;
            edges[2] <= (in_top <= TOP_MIN) ? TOP_FLOOR : in_top;
          end
          2'd2: begin
            edges[3] <= in_left; edges[4] <= in_right;
            edges[5] <= (in_top <= TOP_MIN) ? TOP_FLOOR : in_top;
          end
          2'd3: begin
            edges[6] <= in_left; edges[7] <= in_right;
            edges[8] <= (in_top <= TOP_MIN) ? TOP_FLOOR : in_top;
          end
          default: ;
        endcase
      end
      OP_CLK_EVAL: begin
        edges[0] <= ml; edges[1] <= mr; clk_class <= class_c;
      end
      OP_NORM_INIT: norm_tmp <= sum_acc;
      OP_NORM_STEP: norm_tmp <= norm_tmp >> 1;
      OP_SCAN_INIT: begin
        scan_cnt <= '0; best_d <= 32'hFFFF_FFFF; best_t <= '0;
      end
      OP_SCAN_STEP: begin
        scan_cnt  <= scan_cnt + SCAN_W'(1);
        scan_prev <= mem_q;
        if (scan_cnt >= SCAN_W'(2) && scan_d < best_d) begin
          best_d <= scan_d; best_t <= scan_t;
        end
      end
      OP_DIV_INIT: begin
        div_sel <= 2'd0; div_bit <= 4'd10; div_rem <= 12'd0;
      end
      OP_DIV_STEP: begin
        if (div_bit == 4'd0) begin
          case (div_sel)
            2'd0:    lpos[0] <= div_nx;
            2'd1:    lpos[1] <= div_nx;
            default: lpos[2] <= div_nx;
          endcase
          div_sel <= div_sel + 2'd1;
          div_bit <= 4'd10;
          div_rem <= 12'd0;
        end else begin
          div_bit <= div_bit - 4'd1;
          div_rem <= div_nx;
        end
      end
      default: ;
    endcase
  end

  // phase sum memory
  always_ff @(posedge clk) begin
    if (op == OP_SUM_STORE && pi < PI_W'(PHASE_STEPS))
      sums[pi[PH_W-1:0]] <= sum_norm;
    mem_q <= sums[scan_addr];
  end

  // ---------------- status ----------------
  always_comb begin
    stat.act        = in_act;
    stat.step       = step;
    stat.colour     = colour;
    stat.phase_done = flag_phase;
    stat.pi_lt      = (pi < PI_W'(PHASE_STEPS));
    stat.pi_zero    = (pi == '0);
    stat.dos        = (cfg.act_lines == DOS_LINES_A) || (cfg.act_lines == DOS_LINES_B);
    stat.unstable   = !flag_stable &&
                      (edges[0] > LEFT_LIMIT || edges[3] > LEFT_LIMIT ||
                       edges[6] > LEFT_LIMIT) &&
                      (edges[0] != edges[3] || edges[1] != edges[4]);
    stat.clk_class  = clk_class;
    stat.norm_last  = (norm_tmp[31:1] == 31'd0);
    stat.scan_last  = (scan_cnt == SCAN_W'(PHASE_STEPS + 1));
    stat.div_last   = (div_sel == 2'd2) && (div_bit == 4'd0);
    stat.v_send     = v_send;
    stat.out_free   = !out_valid || !out_stall;
  end

  // ---------------- assertions ----------------
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    op == OP_STORE_PH |=> (step == STEP_IDLE && colour == 2'd0 && !flag_phase))
    else $error("run end did not return to idle");

  a_begin_colour: assert property (@(posedge clk) disable iff (rst)
    op == OP_BEGIN |=> (colour != 2'd0 && step != STEP_IDLE))
    else $error("colour measurement started without a colour");

  a_pi_bound: assert property (@(posedge clk) disable iff (rst)
    pi <= PI_W'(3 * PHASE_STEPS))
    else $error("phase index out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !op_emits(op))
    else $error("output word overwritten while stalled");

endmodule

>>> sv/vga_auto_clock_phase_position.sv
// Top level: configuration registers, sequencer controller and datapath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | input     | in_valid / in_stall       | action, left_edge, right_edge, top_edge,
//          |           |                           | window_sum
//  out     | output    | out_valid / out_stall     | command, argument, last
//  cfg     | input     | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One word is taken at a time; in_stall stays high until its commands are all issued.
// A word passes through load and decode, then one state per command; the clock check,
// the phase search (scan of the 32-entry sum memory, one read per cycle), the sum
// bit-length search and the three bit-serial edge remainders add states of their own,
// as does the skip step when no v start is sent.
// Synchronous reset returns to idle with no clearing pass; stalls on out hold the
// sequencer in place.
module vga_auto_clock_phase_position
  import vacpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [10:0] left_edge,
  input  logic [10:0] right_edge,
  input  logic [10:0] top_edge,
  input  logic [31:0] window_sum,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  command,
  output logic [11:0] argument,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  stat_t stat;
  op_t   op;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.act_width   <= 12'd1024;
      cfg.act_lines   <= 12'd768;
      cfg.hstart      <= 12'd296;
      cfg.vstart      <= 12'd35;
      cfg.nom_total   <= 12'd1344;
      cfg.target      <= 12'd1024;
      cfg.start_total <= 12'd1344;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_ACT_WIDTH:   cfg.act_width   <= pwdata[11:0];
        REG_ACT_LINES:   cfg.act_lines   <= pwdata[11:0];
        REG_HSTART:      cfg.hstart      <= pwdata[11:0];
        REG_VSTART:      cfg.vstart      <= pwdata[11:0];
        REG_NOM_TOTAL:   cfg.nom_total   <= pwdata[11:0];
        REG_TARGET:      cfg.target      <= pwdata[11:0];
        REG_START_TOTAL: cfg.start_total <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_ACT_WIDTH:   prdata = {20'd0, cfg.act_width};
      REG_ACT_LINES:   prdata = {20'd0, cfg.act_lines};
      REG_HSTART:      prdata = {20'd0, cfg.hstart};
      REG_VSTART:      prdata = {20'd0, cfg.vstart};
      REG_NOM_TOTAL:   prdata = {20'd0, cfg.nom_total};
      REG_TARGET:      prdata = {20'd0, cfg.target};
      REG_START_TOTAL: prdata = {20'd0, cfg.start_total};
      default:         prdata = 32'd0;
    endcase
  end

  vacpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .op       (op)
  );

  vacpp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .cfg        (cfg),
    .action     (action),
    .left_edge  (left_edge),
    .right_edge (right_edge),
    .top_edge   (top_edge),
    .window_sum (window_sum),
    .out_stall  (out_stall),
    .stat       (stat),
    .out_valid  (out_valid),
    .command    (command),
    .argument   (argument),
    .last       (last)
  );

endmodule

>>> tb/vga_auto_clock_phase_position_test.sv
// Testbench for the auto clock/phase/position sequencer: random and directed words, scoreboard.
`timescale 1ns / 1ps
module vga_auto_clock_phase_position_test;
  import vacpp_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT = 200;

  typedef struct {
    logic [3:0]  cmd;
    logic [11:0] arg;
    logic        last;
  } command_word_t;

  class autotune_scoreboard;
    logic [11:0] regs[7];
    step_t step;
    int unsigned colour, pixel_total, phase_index, search_count;
    bit stable, clock_done, phase_done;
    int unsigned edges[9];
    int unsigned sum_acc, norm_shift;
    int unsigned phase_sums[PHASE_STEPS];
    int unsigned saved[4];
    command_word_t burst[$];
    command_word_t expected[$];
    int errors, seen;

    function void reset_state();
      regs[REG_ACT_WIDTH] = 1024; regs[REG_ACT_LINES] = 768; regs[REG_HSTART] = 296;
      regs[REG_VSTART] = 35; regs[REG_NOM_TOTAL] = 1344; regs[REG_TARGET] = 1024;
      regs[REG_START_TOTAL] = 1344;
      step = STEP_IDLE; colour = 0; pixel_total = 0; phase_index = 0; search_count = 0;
      stable = 0; clock_done = 0; phase_done = 0; sum_acc = 0; norm_shift = 0;
      foreach (edges[i]) edges[i] = 0;
      foreach (phase_sums[i]) phase_sums[i] = 0;
      foreach (saved[i]) saved[i] = 0;
    endfunction

    function void emit(cmd_t c, int unsigned a);
      command_word_t w;
      if (burst.size() >= 8) return;
      w.cmd = c; w.arg = a[11:0]; w.last = 0;
      burst.push_back(w);
    endfunction

    function int unsigned bias(int unsigned base);
      return base + ((regs[REG_ACT_WIDTH] >= 1280) ? 0 : 1);
    endfunction

    function void begin_colour();
      colour++;
      if (colour > 3) colour = 1;
      step = (clock_done && !phase_done) ? STEP_SUMS : STEP_EDGES;
      emit(CMD_START_MEAS, colour);
    endfunction

    function void phase_point();
      int unsigned best, bestd, a, b, d;
      best = 0; bestd = 32'hFFFFFFFF;
      if (phase_index < PHASE_STEPS) begin
        emit(CMD_SET_PHASE, phase_index);
        begin_colour();
        return;
      end
      for (int t = 0; t < PHASE_STEPS; t++) begin
        a = phase_sums[t];
        b = phase_sums[(t + 1) % PHASE_STEPS];
        d = (a >= b) ? a - b : b - a;
        if (d < bestd) begin
          bestd = d; best = t;
        end
      end
      phase_index = best;
      emit(CMD_SET_PHASE, best);
      saved[3] = best & 8'hFF;
      phase_done = 1;
      emit(CMD_DC_BIAS, bias(4));
      begin_colour();
    endfunction

    function void after_clock();
      colour = 0;
      clock_done = 1;
      emit(CMD_DC_BIAS, bias(2));
      phase_point();
    endfunction

    function void clock_fallback();
      search_count = 0;
      pixel_total = regs[REG_NOM_TOTAL];
      emit(CMD_SET_TOTAL, regs[REG_NOM_TOTAL] - 1);
      phase_index = 0;
      saved[2] = 8'h80;
      after_clock();
    endfunction

    function void clock_check();
      int unsigned rl, rr, gl, gr, bl, br, nom, tgt, active;
      int diff, d;
      rl = edges[0]; rr = edges[1]; gl = edges[3]; gr = edges[4];
      bl = edges[6]; br = edges[7];
      nom = regs[REG_NOM_TOTAL]; tgt = regs[REG_TARGET];
      if (regs[REG_ACT_LINES] == 350 || regs[REG_ACT_LINES] == 400) begin
        pixel_total = nom;
        emit(CMD_SET_TOTAL, nom - 1);
        saved[2] = 8'h80;
        search_count = 0;
        after_clock();
        return;
      end
      if (!stable && (rl > 2040 || gl > 2040 || bl > 2040) && (rl != gl || rr != gr)) begin
        emit(CMD_SET_PHASE, phase_index % PHASE_STEPS);
        phase_index++;
        if (phase_index > 3 * PHASE_STEPS) begin
          stable = 1; phase_index = 0;
        end
        begin_colour();
        return;
      end
      stable = 1;
      if (gl >= bl && bl <= rl) rl = bl;
      if (gr <= br && br >= rr) rr = br;
      if (rl >= gl && gl <= bl) rl = gl;
      if (br <= gr && gr >= rr) rr = gr;
      edges[0] = rl; edges[1] = rr;
      if (rr + 2 < rl) begin
        clock_fallback(); return;
      end
      active = ((rr + 2 - rl) / 2) * 2;
      diff = int'(active) - int'(regs[REG_ACT_WIDTH]);
      if (diff > 127 || diff < -127) begin
        clock_fallback(); return;
      end
      if (active == tgt) begin
        d = int'(pixel_total) - int'(nom);
        if (d != 0 && d <= 4 && d >= -4) pixel_total = nom;
        search_count = 0;
        stable = 0;
        emit(CMD_SET_TOTAL, pixel_total - 1);
        phase_index = 0;
        saved[2] = (8'h80 + pixel_total - nom) & 8'hFF;
        after_clock();
        return;
      end
      if (active <= tgt) pixel_total = (pixel_total + 1) & 12'hFFF;
      else pixel_total = ((((pixel_total - 1) & 12'hFFF) / 2) * 2) & 12'hFFF;
      emit(CMD_SET_TOTAL, pixel_total - 1);
      colour = 0;
      stable = 0;
      search_count = (search_count + 1) & 8'hFF;
      begin_colour();
    endfunction

    function int unsigned left_pos(int unsigned e);
      if (regs[REG_NOM_TOTAL] != 0) e = e % regs[REG_NOM_TOTAL];
      return (e - EDGE_OFFSET) & 16'hFFFF;
    endfunction

    function int unsigned dist4(int unsigned t);
      return (t >= 4) ? t - 4 : 4 - t;
    endfunction

    function void position();
      int unsigned rl, gl, bl, rt, gt, bt, hs, vs, h, t, v;
      rl = left_pos(edges[0]); gl = left_pos(edges[3]); bl = left_pos(edges[6]);
      rt = edges[2]; gt = edges[5]; bt = edges[8];
      hs = regs[REG_HSTART]; vs = regs[REG_VSTART];
      if (rl <= gl && rl <= bl) h = rl;
      else if (gl <= rl && gl <= bl) h = gl;
      else h = bl;
      if (h > hs + 255) h = hs;
      emit(CMD_HSTART, h);
      saved[0] = (hs + 8'h80 - h) & 8'hFF;
      if ((rt <= gt && rt <= bt) || (gt <= rt && gt <= bt)) begin
        t = (rt <= gt && rt <= bt) ? rt : gt;
        if (t <= vs + 50) begin
          v = dist4(t);
          emit(CMD_VSTART, v);
          saved[1] = v & 8'hFF;
        end else begin
          saved[1] = vs & 8'hFF;
        end
      end else begin
        t = bt;
        if (t > vs + 50) t = vs;
        v = dist4(t);
        emit(CMD_VSTART, v);
        saved[1] = v & 8'hFF;
      end
      emit(CMD_RESTORE, 0);
      emit(CMD_STORE_H, saved[0]);
      emit(CMD_STORE_V, saved[1]);
      emit(CMD_STORE_CLK, saved[2]);
      emit(CMD_STORE_PHASE, saved[3]);
      stable = 0; clock_done = 0; phase_done = 0;
      colour = 0;
      step = STEP_IDLE;
    endfunction

    function void note_word(logic [1:0] act, logic [10:0] l, logic [10:0] r,
                            logic [10:0] tp, logic [31:0] s);
      int unsigned b, sh, tmp;
      burst.delete();
      if (act == ACT_ABORT) begin
        step = STEP_IDLE; colour = 0; stable = 0; clock_done = 0; phase_done = 0;
      end else if (act == ACT_START) begin
        stable = 0; clock_done = 0; phase_done = 0;
        colour = 0; phase_index = 0; search_count = 0;
        pixel_total = regs[REG_START_TOTAL];
        emit(CMD_LEVELS, 0);
        emit(CMD_DC_BIAS, bias(0));
        begin_colour();
      end else if (act == ACT_MEAS && step == STEP_EDGES && colour >= 1 && colour <= 3) begin
        b = (colour - 1) * 3;
        edges[b] = l; edges[b + 1] = r;
        edges[b + 2] = (tp <= 4) ? 200 : tp;
        if (colour < 3) begin_colour();
        else if (!phase_done) clock_check();
        else position();
      end else if (act == ACT_MEAS && step == STEP_SUMS && colour >= 1 && colour <= 3) begin
        if (colour == 1) sum_acc = s;
        else sum_acc = sum_acc + s;
        if (colour < 3) begin
          begin_colour();
        end else begin
          if (phase_index == 0) begin
            tmp = sum_acc;
            norm_shift = 0;
            do begin
              norm_shift++; tmp >>= 1;
            end while (tmp != 0);
          end
          sh = (norm_shift > 11) ? norm_shift - 11 : 0;
          if (sh > 31) sh = 31;
          if (phase_index < PHASE_STEPS) phase_sums[phase_index] = sum_acc >> sh;
          phase_index++;
          phase_point();
        end
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1;
      foreach (burst[i]) expected.push_back(burst[i]);
    endfunction

    function void check_word(logic [3:0] c, logic [11:0] a, logic l);
      command_word_t w;
      seen++;
      if (expected.size() == 0) begin
        $display("%0t: unexpected word cmd=%0d arg=%0d last=%0d", $time, c, a, l);
        errors++;
        return;
      end
      w = expected.pop_front();
      if (w.cmd !== c || w.arg !== a || w.last !== l) begin
        $display("%0t: mismatch expected cmd=%0d arg=%0d last=%0d, got cmd=%0d arg=%0d last=%0d",
                 $time, w.cmd, w.arg, w.last, c, a, l);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] action;
  logic [10:0] left_edge, right_edge, top_edge;
  logic [31:0] window_sum;
  logic out_valid, out_stall;
  logic [3:0] command;
  logic [11:0] argument;
  logic last;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  vga_auto_clock_phase_position dut (.*);

  autotune_scoreboard sb = new();
  int idle_pct, stall_pct, hold_left, cycles, sent_words, sequences;
  int unsigned good_l, good_r;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_word(command, argument, last);

  // in_stall only moves at rising edges, so its value at the falling edge holds
  // through the next rising edge, which is where the word is taken
  task automatic send_word(logic [1:0] act, logic [10:0] l, logic [10:0] r,
                           logic [10:0] tp, logic [31:0] s);
    in_valid <= 1'b1;
    action <= act; left_edge <= l; right_edge <= r; top_edge <= tp; window_sum <= s;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sb.note_word(act, l, r, tp, s);
    if (act == ACT_START) begin
      sequences++;
      good_l = $urandom_range(2, 2047 - sb.regs[REG_TARGET]);
      good_r = good_l + sb.regs[REG_TARGET] - 2;
    end
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [11:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(4 * idx); pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.regs[idx] = val;
  endtask

  task automatic configure(logic [11:0] w, logic [11:0] ln, logic [11:0] hs, logic [11:0] vs,
                           logic [11:0] nom, logic [11:0] tgt, logic [11:0] st);
    write_reg(REG_ACT_WIDTH, w); write_reg(REG_ACT_LINES, ln);
    write_reg(REG_HSTART, hs); write_reg(REG_VSTART, vs);
    write_reg(REG_NOM_TOTAL, nom); write_reg(REG_TARGET, tgt);
    write_reg(REG_START_TOTAL, st);
  endtask

  function automatic logic [10:0] rand_top();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 11'($urandom_range(0, 6));
    if (r < 60) return 11'($urandom_range(0, 150));
    return 11'($urandom_range(0, 2047));
  endfunction

  // mostly well-formed runs: start, edges, sums, edges; a little noise
  task automatic random_words(int count);
    int r, done;
    logic [10:0] l, rr;
    logic [31:0] s;
    done = 0;
    while (done < count) begin
      r = $urandom_range(999);
      if (sb.step == STEP_IDLE) begin
        if (r < 850) begin
          send_word(ACT_START, 11'($urandom), 11'($urandom), 11'($urandom), $urandom);
          done++;
        end else if (r < 900) begin
          send_word(ACT_ABORT, 11'($urandom), 11'($urandom), 11'($urandom), $urandom);
          done++;
        end else begin
          send_word(r[0] ? ACT_MEAS : ACT_UNUSED, 11'($urandom), 11'($urandom),
                    11'($urandom), $urandom);
        end
      end else if (r < 5) begin
        send_word(ACT_ABORT, 11'($urandom), 11'($urandom), 11'($urandom), $urandom);
        done++;
      end else if (r < 10) begin
        send_word(ACT_START, 11'($urandom), 11'($urandom), 11'($urandom), $urandom);
        done++;
      end else if (r < 20) begin
        send_word(ACT_UNUSED, 11'($urandom), 11'($urandom), 11'($urandom), $urandom);
      end else if (sb.step == STEP_EDGES) begin
        r = $urandom_range(99);
        if (r < 75) begin
          l = good_l; rr = good_r;
        end else if (r < 85) begin
          l = 11'($urandom_range(2041, 2047)); rr = 11'($urandom);
        end else if (r < 95) begin
          l = 11'($urandom); rr = 11'($urandom);
        end else begin
          l = 11'($urandom_range(100, 2047)); rr = 11'($urandom_range(0, l - 3));
        end
        send_word(ACT_MEAS, l, rr, rand_top(), $urandom);
        done++;
      end else begin
        r = $urandom_range(99);
        if (r < 10) s = 32'hFFFFFFFF;
        else if (r < 15) s = 0;
        else s = $urandom >> $urandom_range(0, 31);
        send_word(ACT_MEAS, 11'($urandom), 11'($urandom), 11'($urandom), s);
        done++;
      end
    end
  endtask

  initial begin
    rst = 1'b1; in_valid = 1'b0; action = ACT_START;
    left_edge = '0; right_edge = '0; top_edge = '0; window_sum = '0;
    out_stall = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    cycles = 0; hold_left = 0; idle_pct = 0; stall_pct = 0;
    sent_words = 0; sequences = 0;
    sb.reset_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ignored words, unstable phase, reversed edges, extremes
    send_word(ACT_MEAS, 11'd5, 11'd5, 11'd5, 32'd5);
    send_word(ACT_UNUSED, 11'd0, 11'd0, 11'd0, 32'd0);
    send_word(ACT_START, 11'd0, 11'd0, 11'd0, 32'd0);
    send_word(ACT_MEAS, 11'd2047, 11'd2047, 11'd0, 32'd0);
    send_word(ACT_MEAS, 11'd100, 11'd1122, 11'd4, 32'd0);
    send_word(ACT_MEAS, 11'd100, 11'd1122, 11'd2047, 32'd0);
    send_word(ACT_MEAS, 11'd1500, 11'd10, 11'd40, 32'd0);
    send_word(ACT_ABORT, 11'd0, 11'd0, 11'd0, 32'd0);
    send_word(ACT_START, 11'd0, 11'd0, 11'd0, 32'd0);
    send_word(ACT_MEAS, 11'd1500, 11'd10, 11'd40, 32'd0);
    send_word(ACT_MEAS, 11'd1600, 11'd0, 11'd30, 32'd0);
    send_word(ACT_MEAS, 11'd1700, 11'd20, 11'd1, 32'd0);
    send_word(ACT_MEAS, 11'd0, 11'd0, 11'd0, 32'hFFFFFFFF);
    send_word(ACT_MEAS, 11'd0, 11'd0, 11'd0, 32'hFFFFFFFF);
    send_word(ACT_MEAS, 11'd0, 11'd0, 11'd0, 32'd0);
    send_word(ACT_MEAS, 11'd0, 11'd0, 11'd0, 32'd0);
    send_word(ACT_START, 11'd0, 11'd0, 11'd0, 32'd0);
    send_word(ACT_MEAS, 11'd100, 11'd1122, 11'd60, 32'd0);
    send_word(ACT_MEAS, 11'd100, 11'd1122, 11'd60, 32'd0);
    send_word(ACT_MEAS, 11'd100, 11'd1122, 11'd60, 32'd0);
    send_word(ACT_MEAS, 11'd0, 11'd0, 11'd0, 32'h00000001);
    random_words(60);
    drain();

    configure(12'd1280, 12'd768, 12'd0, 12'd0, 12'd4095, 12'd1280, 12'd4095);
    idle_pct = 55; stall_pct = 0;
    random_words(75);
    drain();

    configure(12'd640, 12'd350, 12'd4095, 12'd4095, 12'd0, 12'd640, 12'd1);
    idle_pct = 0; stall_pct = 55;
    hold_left <= 400;
    random_words(75);
    drain();

    configure(12'd1990, 12'd400, 12'd100, 12'd2000, 12'd800, 12'd1990, 12'd700);
    idle_pct = 20; stall_pct = 20;
    random_words(75);
    drain();

    configure(12'd0, 12'd4095, 12'd300, 12'd10, 12'd1, 12'd0, 12'd2);
    idle_pct = 30; stall_pct = 40;
    random_words(75);
    drain();

    $display("Covered %0d autotune runs over five register settings and five pacing mixes;",
             sequences);
    $display("%0d command words checked, %0d errors.", sb.seen, sb.errors);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
